FILE: rtl/nrte_pkg.sv
`timescale 1ns / 1ps

package nrte_pkg;

    localparam logic [3:0] C_MIN_LEN       = 4'd15;
    localparam logic [4:0] C_ZONE_RESET    = 5'd8;
    localparam logic [4:0] C_HOURS_PER_DAY = 5'd24;
    localparam logic [5:0] C_RECIP_24      = 6'd43;
    localparam int         C_RECIP_SHIFT   = 10;
    localparam logic [7:0] C_CHAR_STAR     = 8'h2A;
    localparam logic [7:0] C_CHAR_COMMA    = 8'h2C;
    localparam logic [7:0] C_CHAR_STATUS   = 8'h41;
    localparam logic [2:0] C_TIME_DIGITS   = 3'd6;
    localparam logic [2:0] C_HEADER_LAST   = 3'd5;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_SEEK1,
        PH_TIME,
        PH_SEEK2,
        PH_STATUS,
        PH_DONE
    } t_phase;

    typedef enum logic [1:0] {
        CK_BEFORE,
        CK_HEX1,
        CK_HEX2,
        CK_DONE
    } t_ck_phase;

    typedef struct packed {
        logic [7:0] character;
        logic       last;
    } t_in;

    typedef struct packed {
        logic [4:0] hours;
        logic [6:0] minutes;
        logic [6:0] seconds;
        logic       have_time;
        logic       accepted;
    } t_out;

    typedef logic [5:0][3:0] t_digits;

    typedef struct packed {
        logic    ok;
        t_digits digits;
    } t_rec;

    function automatic logic [7:0] header_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = 8'h24;
            3'd1:    c = 8'h47;
            3'd2:    c = 8'h50;
            3'd3:    c = 8'h52;
            3'd4:    c = 8'h4D;
            default: c = 8'h43;
        endcase
        return c;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    // Returns the hex value in the low four bits and a valid flag on top.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [7:0] d;
        logic [4:0] r;
        d = 8'h00;
        r = 5'd0;
        if (is_digit(c)) begin
            d = c - 8'h30;
            r = {1'b1, d[3:0]};
        end else if ((c >= 8'h41) && (c <= 8'h46)) begin
            d = c - 8'h37;
            r = {1'b1, d[3:0]};
        end
        return r;
    endfunction

    function automatic logic [6:0] two_digits(input logic [3:0] hi, input logic [3:0] lo);
        return {hi, 3'b000} + {2'b00, hi, 1'b0} + {3'b000, lo};
    endfunction

endpackage

FILE: rtl/nrte_front.sv
`timescale 1ns / 1ps

module nrte_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  nrte_pkg::t_in i_data,
    output logic          o_push,
    output nrte_pkg::t_rec o_rec
);
    import nrte_pkg::*;

    t_phase     r_phase, n_phase;
    t_ck_phase  r_ck, n_ck;
    logic [3:0] r_count, n_count;
    logic       r_header_ok, n_header_ok;
    logic [2:0] r_tidx, n_tidx;
    logic       r_digits_ok, n_digits_ok;
    logic [7:0] r_xor, n_xor;
    logic [7:0] r_recv, n_recv;
    logic       r_hex_ok, n_hex_ok;
    logic       r_status_ok, n_status_ok;
    t_digits    r_digits, n_digits;
    logic       w_ok;
    logic [4:0] w_hex;
    logic [7:0] w_c;

    assign w_c = i_data.character;

    always_comb begin
        n_phase     = r_phase;
        n_ck        = r_ck;
        n_count     = r_count;
        n_header_ok = r_header_ok;
        n_tidx      = r_tidx;
        n_digits_ok = r_digits_ok;
        n_xor       = r_xor;
        n_recv      = r_recv;
        n_hex_ok    = r_hex_ok;
        n_status_ok = r_status_ok;
        n_digits    = r_digits;
        w_hex       = hex_value(w_c);
        w_ok        = 1'b0;
        if (i_accept) begin
            unique case (r_phase)
                PH_HEADER: begin
                    if (w_c != header_char(r_count < 4'd6 ? r_count[2:0] : C_HEADER_LAST)) begin
                        n_header_ok = 1'b0;
                    end
                    if (r_count >= {1'b0, C_HEADER_LAST}) begin
                        n_phase = PH_SEEK1;
                    end
                end
                PH_SEEK1: begin
                    if (w_c == C_CHAR_COMMA) begin
                        n_phase = PH_TIME;
                        n_tidx  = 3'd0;
                    end
                end
                PH_TIME: begin
                    if (is_digit(w_c)) begin
                        n_digits[r_tidx] = w_c[3:0];
                    end else begin
                        n_digits_ok = 1'b0;
                    end
                    n_tidx = r_tidx + 3'd1;
                    if (n_tidx >= C_TIME_DIGITS) begin
                        n_phase = PH_SEEK2;
                    end
                end
                PH_SEEK2: begin
                    if (w_c == C_CHAR_COMMA) begin
                        n_phase = PH_STATUS;
                    end
                end
                PH_STATUS: begin
                    n_status_ok = (w_c == C_CHAR_STATUS);
                    n_phase     = PH_DONE;
                end
                default: begin
                end
            endcase

            unique case (r_ck)
                CK_BEFORE: begin
                    if (r_count != 4'd0) begin
                        if (w_c == C_CHAR_STAR) begin
                            n_ck = CK_HEX1;
                        end else begin
                            n_xor = r_xor ^ w_c;
                        end
                    end
                end
                CK_HEX1: begin
                    n_recv = {w_hex[3:0], 4'h0};
                    n_hex_ok = r_hex_ok & w_hex[4];
                    n_ck = CK_HEX2;
                end
                CK_HEX2: begin
                    n_recv = r_recv | {4'h0, w_hex[3:0]};
                    n_hex_ok = r_hex_ok & w_hex[4];
                    n_ck = CK_DONE;
                end
                default: begin
                end
            endcase

            if (r_count != C_MIN_LEN) begin
                n_count = r_count + 4'd1;
            end

            w_ok = (n_count == C_MIN_LEN) && n_header_ok && (n_phase == PH_DONE) &&
                   n_digits_ok && n_status_ok && (n_ck == CK_DONE) && n_hex_ok &&
                   (n_xor == n_recv);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_data.last)) begin
            r_phase     <= PH_HEADER;
            r_ck        <= CK_BEFORE;
            r_count     <= 4'd0;
            r_header_ok <= 1'b1;
            r_tidx      <= 3'd0;
            r_digits_ok <= 1'b1;
            r_xor       <= 8'h00;
            r_recv      <= 8'h00;
            r_hex_ok    <= 1'b1;
            r_status_ok <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_ck        <= n_ck;
            r_count     <= n_count;
            r_header_ok <= n_header_ok;
            r_tidx      <= n_tidx;
            r_digits_ok <= n_digits_ok;
            r_xor       <= n_xor;
            r_recv      <= n_recv;
            r_hex_ok    <= n_hex_ok;
            r_status_ok <= n_status_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_digits <= n_digits;
    end

    assign o_push       = i_accept & i_data.last;
    assign o_rec.ok     = w_ok;
    assign o_rec.digits = n_digits;

endmodule

FILE: rtl/nrte_queue.sv
`timescale 1ns / 1ps

module nrte_queue #(
    parameter int DEPTH = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  nrte_pkg::t_rec i_rec,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_nonempty,
    output nrte_pkg::t_rec o_rec
);
    import nrte_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_rec          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          w_do_push;
    logic          w_do_pop;

    assign o_full     = (r_count == FULL_CNT);
    assign o_nonempty = (r_count != '0);
    assign o_rec      = r_mem[r_rd_ptr];
    assign w_do_push  = i_push & ~o_full;
    assign w_do_pop   = i_pop & o_nonempty;

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!w_do_push && w_do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/nrte_back.sv
`timescale 1ns / 1ps

module nrte_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_rec_valid,
    input  nrte_pkg::t_rec i_rec,
    input  logic [4:0]     i_zone,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_stall,
    output nrte_pkg::t_out o_data
);
    import nrte_pkg::*;

    t_digits     r_saved;
    logic        r_have;
    logic        r_a_valid;
    logic [7:0]  r_a_hraw;
    logic [6:0]  r_a_min;
    logic [6:0]  r_a_sec;
    logic        r_a_have;
    logic        r_a_acc;
    logic        r_o_valid;
    t_out        r_o_data;
    logic        w_out_adv;
    logic        w_a_adv;
    logic        w_take;
    t_digits     w_sel;
    logic        w_have;
    logic [12:0] w_prod;
    logic [2:0]  w_quot;
    logic [7:0]  w_rem;

    assign w_out_adv = ~r_o_valid | ~i_stall;
    assign w_a_adv   = ~r_a_valid | w_out_adv;
    assign w_take    = w_a_adv & i_rec_valid;
    assign o_pop     = w_take;
    assign w_sel     = i_rec.ok ? i_rec.digits : r_saved;
    assign w_have    = r_have | i_rec.ok;

    // Hour modulo 24 through a reciprocal multiply; exact for sums below 131.
    assign w_prod = {5'd0, r_a_hraw} * {7'd0, C_RECIP_24};
    assign w_quot = w_prod[C_RECIP_SHIFT +: 3];
    assign w_rem  = r_a_hraw - {1'b0, w_quot, 4'h0} - {2'b00, w_quot, 3'h0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have    <= 1'b0;
            r_a_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (w_take && i_rec.ok) begin
                r_have <= 1'b1;
            end
            if (w_a_adv) begin
                r_a_valid <= i_rec_valid;
            end
            if (w_out_adv) begin
                r_o_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && i_rec.ok) begin
            r_saved <= i_rec.digits;
        end
        if (w_take) begin
            r_a_have <= w_have;
            r_a_acc  <= i_rec.ok;
            if (w_have) begin
                r_a_hraw <= {1'b0, two_digits(w_sel[0], w_sel[1])} + {3'b000, i_zone};
                r_a_min  <= two_digits(w_sel[2], w_sel[3]);
                r_a_sec  <= two_digits(w_sel[4], w_sel[5]);
            end else begin
                r_a_hraw <= 8'd0;
                r_a_min  <= 7'd0;
                r_a_sec  <= 7'd0;
            end
        end
        if (w_out_adv && r_a_valid) begin
            r_o_data.hours     <= w_rem[4:0];
            r_o_data.minutes   <= r_a_min;
            r_o_data.seconds   <= r_a_sec;
            r_o_data.have_time <= r_a_have;
            r_o_data.accepted  <= r_a_acc;
        end
    end

    assign o_valid = r_o_valid;
    assign o_data  = r_o_data;

endmodule

FILE: rtl/nmea_rmc_time_extractor.sv
`timescale 1ns / 1ps

// Channel   Handshake             Payload       Direction
// input     i_valid / o_stall     i_data        one character per transfer
// output    o_valid / i_stall     o_data        one result per sentence end
// config    i_cfg_we              i_cfg_wdata   zone offset in hours
//
// The parser takes one character every cycle unless stalled; its state is a small set of registers.
// From the queue, each sentence's record is registered in the A stage, then in the output register.
// The input stalls only when the end-of-sentence queue is full.
// Reset is synchronous and clears all control state; the zone offset resets to 8.

module nmea_rmc_time_extractor #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  nrte_pkg::t_in   i_data,
    output logic            o_valid,
    input  logic            i_stall,
    output nrte_pkg::t_out  o_data,
    input  logic            i_cfg_we,
    input  logic [4:0]      i_cfg_wdata
);
    import nrte_pkg::*;

    logic [4:0] r_zone;
    logic       w_accept;
    logic       w_push;
    t_rec       w_push_rec;
    logic       w_full;
    logic       w_nonempty;
    t_rec       w_head;
    logic       w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zone <= C_ZONE_RESET;
        end else if (i_cfg_we) begin
            r_zone <= i_cfg_wdata;
        end
    end

    assign o_stall  = w_full;
    assign w_accept = i_valid & ~w_full;

    nrte_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(w_accept),
        .i_data  (i_data),
        .o_push  (w_push),
        .o_rec   (w_push_rec)
    );

    nrte_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (w_push),
        .i_rec     (w_push_rec),
        .i_pop     (w_pop),
        .o_full    (w_full),
        .o_nonempty(w_nonempty),
        .o_rec     (w_head)
    );

    nrte_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rec_valid(w_nonempty),
        .i_rec      (w_head),
        .i_zone     (r_zone),
        .o_pop      (w_pop),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_data     (o_data)
    );

    a_hours_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.hours < C_HOURS_PER_DAY))
        else $error("hours out of range");

    a_accept_has_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.accepted) |-> o_data.have_time)
        else $error("accepted sentence without saved time");

    a_no_time_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_data.have_time) |->
            (o_data.hours == 5'd0 && o_data.minutes == 7'd0 && o_data.seconds == 7'd0))
        else $error("time fields set before any accepted sentence");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_full |-> !w_push)
        else $error("push into full queue");

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import nrte_pkg::*;

    localparam int          CYCLE_LIMIT = 200000;
    localparam int          HOLD_CYCLES = 250;
    localparam int          SETTLE      = 8;
    localparam logic [47:0] RMC_TAG     = "$GPRMC";
    localparam logic [7:0]  CH_ZERO     = 8'h30;
    localparam logic [7:0]  CH_NINE     = 8'h39;
    localparam logic [7:0]  CH_UPPER_A  = 8'h41;
    localparam logic [7:0]  CH_UPPER_F  = 8'h46;
    localparam logic [7:0]  CH_LOWER_A  = 8'h61;
    localparam logic [7:0]  CH_CR       = 8'h0D;
    localparam logic [7:0]  CH_LF       = 8'h0A;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    t_in        i_data = '0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    t_out       o_data;
    logic       i_cfg_we = 1'b0;
    logic [4:0] i_cfg_wdata = '0;

    nmea_rmc_time_extractor u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Parser image kept alongside the block.
    logic [4:0] zone_hours;
    t_phase     scan_phase;
    t_ck_phase  sum_phase;
    logic [3:0] sent_len;
    bit         hdr_match;
    logic [3:0] tm_digits [6];
    int         tm_idx;
    bit         tm_ok;
    logic [7:0] xor_acc;
    logic [7:0] sum_rx;
    bit         sum_hex_ok;
    bit         status_a;
    logic [3:0] kept_time [6];
    bit         kept_flag;

    t_in        tx_chars [$];
    t_out       due_fixes [$];
    logic [7:0] sentence_buf [$];

    int  tx_idle_pct = 0;
    int  rx_stall_pct = 0;
    int  chars_queued = 0;
    int  chars_taken = 0;
    int  sentences_sent = 0;
    int  fixes_seen = 0;
    int  accepted_seen = 0;
    int  errors = 0;
    int  cycle_count = 0;
    int  hold_left = 0;
    bit  hold_arm = 1'b0;
    t_out oldest_fix;

    function automatic void restart_sentence();
        scan_phase = PH_HEADER;
        sum_phase  = CK_BEFORE;
        sent_len   = 4'd0;
        hdr_match  = 1'b1;
        tm_idx     = 0;
        tm_ok      = 1'b1;
        xor_acc    = 8'h00;
        sum_rx     = 8'h00;
        sum_hex_ok = 1'b1;
        status_a   = 1'b0;
    endfunction

    function automatic bit upper_hex(input logic [7:0] c, output logic [3:0] v);
        v = 4'h0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            v = 4'(c - CH_ZERO);
            return 1'b1;
        end
        if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
            v = 4'(c - CH_UPPER_A + 8'd10);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void advance_parser(input t_in item);
        logic [7:0] c;
        logic [3:0] pos;
        logic [3:0] nib;
        int         tag_idx;
        bit         good;
        t_out       fix;
        c = item.character;
        pos = sent_len;
        case (scan_phase)
            PH_HEADER: begin
                tag_idx = (pos < 4'd6) ? int'(pos) : 5;
                if (c != RMC_TAG[47 - 8 * tag_idx -: 8]) hdr_match = 1'b0;
                if (pos >= 4'd5) scan_phase = PH_SEEK1;
            end
            PH_SEEK1: begin
                if (c == C_CHAR_COMMA) begin
                    scan_phase = PH_TIME;
                    tm_idx = 0;
                end
            end
            PH_TIME: begin
                if (c >= CH_ZERO && c <= CH_NINE) tm_digits[tm_idx] = 4'(c - CH_ZERO);
                else tm_ok = 1'b0;
                tm_idx++;
                if (tm_idx >= 6) scan_phase = PH_SEEK2;
            end
            PH_SEEK2: begin
                if (c == C_CHAR_COMMA) scan_phase = PH_STATUS;
            end
            PH_STATUS: begin
                status_a = (c == C_CHAR_STATUS);
                scan_phase = PH_DONE;
            end
            default: ;
        endcase
        case (sum_phase)
            CK_BEFORE: begin
                if (pos != 4'd0) begin
                    if (c == C_CHAR_STAR) sum_phase = CK_HEX1;
                    else xor_acc ^= c;
                end
            end
            CK_HEX1: begin
                sum_hex_ok &= upper_hex(c, nib);
                sum_rx = {nib, 4'h0};
                sum_phase = CK_HEX2;
            end
            CK_HEX2: begin
                sum_hex_ok &= upper_hex(c, nib);
                sum_rx[3:0] = nib;
                sum_phase = CK_DONE;
            end
            default: ;
        endcase
        if (sent_len < 4'd15) sent_len++;
        if (item.last) begin
            good = sent_len >= 4'd15 && hdr_match && scan_phase == PH_DONE && tm_ok &&
                   status_a && sum_phase == CK_DONE && sum_hex_ok && xor_acc == sum_rx;
            if (good) begin
                kept_time = tm_digits;
                kept_flag = 1'b1;
            end
            fix = '0;
            if (kept_flag) begin
                fix.hours   = 5'((int'(kept_time[0]) * 10 + int'(kept_time[1]) +
                                  int'(zone_hours)) % 24);
                fix.minutes = 7'(int'(kept_time[2]) * 10 + int'(kept_time[3]));
                fix.seconds = 7'(int'(kept_time[4]) * 10 + int'(kept_time[5]));
            end
            fix.have_time = kept_flag;
            fix.accepted  = good;
            due_fixes.push_back(fix);
            restart_sentence();
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                advance_parser(i_data);
                chars_taken++;
            end
            if (!i_valid || !o_stall) begin
                if (tx_chars.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    i_valid <= 1'b1;
                    i_data <= tx_chars.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (due_fixes.size() == 0) begin
                    $display("%0t: result transfer with nothing expected, got %p", $time, o_data);
                    errors++;
                end else begin
                    oldest_fix = due_fixes.pop_front();
                    check_field("hours", 32'(oldest_fix.hours), 32'(o_data.hours));
                    check_field("minutes", 32'(oldest_fix.minutes), 32'(o_data.minutes));
                    check_field("seconds", 32'(oldest_fix.seconds), 32'(o_data.seconds));
                    check_field("have_time", 32'(oldest_fix.have_time),
                                32'(o_data.have_time));
                    check_field("accepted", 32'(oldest_fix.accepted), 32'(o_data.accepted));
                    fixes_seen++;
                    if (oldest_fix.accepted) accepted_seen++;
                end
            end
            i_stall <= (hold_left != 0) || ($urandom_range(99) < rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_arm) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycle_count, due_fixes.size());
            $display("nmea_rmc_time_extractor verification failed");
            $finish;
        end
    end

    function automatic logic [7:0] hex_char(input logic [3:0] v, input bit lower);
        if (v < 4'd10) return CH_ZERO + {4'h0, v};
        return (lower ? CH_LOWER_A : CH_UPPER_A) + {4'h0, v} - 8'd10;
    endfunction

    function automatic logic [7:0] filler_byte();
        logic [7:0] b;
        b = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(126, 32));
        if (b == C_CHAR_STAR) b = C_CHAR_COMMA;
        return b;
    endfunction

    task automatic put_text(input string s);
        for (int k = 0; k < s.len(); k++) sentence_buf.push_back(s[k]);
    endtask

    task automatic put_checksum(input bit lower, input logic [7:0] spoil);
        logic [7:0] sum;
        sum = spoil;
        for (int k = 1; k < sentence_buf.size(); k++) sum ^= sentence_buf[k];
        sentence_buf.push_back(C_CHAR_STAR);
        sentence_buf.push_back(hex_char(sum[7:4], lower));
        sentence_buf.push_back(hex_char(sum[3:0], lower));
    endtask

    task automatic send_sentence(input int keep);
        int  n;
        t_in item;
        n = (keep > 0 && keep < sentence_buf.size()) ? keep : sentence_buf.size();
        for (int k = 0; k < n; k++) begin
            item.character = sentence_buf[k];
            item.last = (k == n - 1);
            tx_chars.push_back(item);
        end
        chars_queued += n;
        sentences_sent++;
        sentence_buf.delete();
    endtask

    task automatic queue_text(input string body, input bit seal, input bit lower,
                              input logic [7:0] spoil, input int keep);
        sentence_buf.delete();
        put_text(body);
        if (seal) put_checksum(lower, spoil);
        send_sentence(keep);
    endtask

    task automatic queue_random_sentence();
        int pick;
        int keep;
        pick = $urandom_range(99);
        keep = 0;
        sentence_buf.delete();
        if (pick >= 88) begin
            if (pick >= 95) put_text("$GPRMC,");
            repeat ($urandom_range(12, 1)) sentence_buf.push_back(8'($urandom_range(255)));
        end else begin
            put_text("$GPRMC,");
            if (pick >= 76 && pick < 82) sentence_buf[$urandom_range(5)] = 8'($urandom_range(255));
            for (int k = 0; k < 6; k++) begin
                if ($urandom_range(99) < 4) sentence_buf.push_back(filler_byte());
                else sentence_buf.push_back(CH_ZERO + 8'($urandom_range(9)));
            end
            if ($urandom_range(1) == 1) begin
                put_text(".");
                repeat (2) sentence_buf.push_back(CH_ZERO + 8'($urandom_range(9)));
            end
            sentence_buf.push_back(C_CHAR_COMMA);
            sentence_buf.push_back(($urandom_range(99) < 88) ? C_CHAR_STATUS : filler_byte());
            repeat ($urandom_range(2)) begin
                sentence_buf.push_back(C_CHAR_COMMA);
                repeat ($urandom_range(5)) sentence_buf.push_back(filler_byte());
            end
            put_checksum(pick >= 66 && pick < 72,
                         (pick >= 60 && pick < 66) ? 8'($urandom_range(255, 1)) : 8'h00);
            if ($urandom_range(4) == 0) begin
                sentence_buf.push_back(CH_CR);
                sentence_buf.push_back(CH_LF);
            end
            if (pick >= 72 && pick < 76) keep = $urandom_range(sentence_buf.size() - 1, 1);
        end
        send_sentence(keep);
    endtask

    task automatic wait_drained();
        while (chars_taken != chars_queued || due_fixes.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_zone(input logic [4:0] hrs);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= hrs;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        zone_hours = hrs;
    endtask

    task automatic run_random_phase(input int tx_pct, input int rx_pct);
        int start_chars;
        tx_idle_pct = tx_pct;
        rx_stall_pct = rx_pct;
        start_chars = chars_queued;
        while (chars_queued - start_chars < 25)
            queue_random_sentence();
        wait_drained();
    endtask

    initial begin
        zone_hours = C_ZONE_RESET;
        kept_flag = 1'b0;
        foreach (kept_time[k]) kept_time[k] = 4'd0;
        foreach (tm_digits[k]) tm_digits[k] = 4'd0;
        restart_sentence();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        sentence_buf.push_back(8'h00);
        send_sentence(0);
        queue_text("$GPRMC,081530,V", 1, 0, 8'h00, 0);
        queue_text("$GPRMC,235959,A", 1, 0, 8'h00, 0);
        put_text("$GPRMC,000000,A,,");
        put_checksum(0, 8'h00);
        sentence_buf.push_back(CH_CR);
        sentence_buf.push_back(CH_LF);
        send_sentence(0);
        queue_text("$GPRMC,123519,A", 0, 0, 8'h00, 0);
        queue_text("$GPRMC,1235", 0, 0, 8'h00, 0);
        queue_text("$GPRMC,123519,A", 1, 0, 8'h00, 17);
        queue_text("$GPRMC,123519,A,W", 1, 1, 8'h00, 0);
        queue_text("$GPRMC,123519,A", 1, 0, 8'h01, 0);
        queue_text("$GPRMC,12a519,A", 1, 0, 8'h00, 0);
        queue_text("$GPGGA,123519,A", 1, 0, 8'h00, 0);
        queue_text("*GPRMC,123519,A", 1, 0, 8'h00, 0);
        queue_text("$GPRMCX,101010,A", 1, 0, 8'h00, 0);
        queue_text("$GPRMC,12,A,345,A", 1, 0, 8'h00, 0);
        put_text("$GPRMC,995959,A,");
        sentence_buf.push_back(8'h00);
        sentence_buf.push_back(8'hFF);
        put_checksum(0, 8'h00);
        send_sentence(0);
        sentence_buf.push_back(8'hFF);
        send_sentence(0);
        wait_drained();

        set_zone(5'd0);
        run_random_phase(0, 0);
        set_zone(5'd23);
        run_random_phase(47, 0);
        set_zone(5'd31);
        run_random_phase(0, 47);
        set_zone(5'($urandom_range(22, 1)));
        run_random_phase(11, 11);

        // Receiver holds off while short sentences keep arriving, so the block backs up.
        set_zone(5'($urandom_range(30, 24)));
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        @(posedge i_clk);
        hold_arm <= 1'b1;
        @(posedge i_clk);
        hold_arm <= 1'b0;
        repeat (8) begin
            if ($urandom_range(3) == 0) begin
                queue_random_sentence();
            end else begin
                repeat ($urandom_range(3, 1)) sentence_buf.push_back(8'($urandom_range(255)));
                send_sentence(0);
            end
        end
        wait_drained();

        $display("Sent %0d sentences (%0d characters); %0d results checked, %0d accepted.",
                 sentences_sent, chars_queued, fixes_seen, accepted_seen);
        $display("Zone offsets from 0 to 31, idle and stall mixes, and a long output hold-off.");
        if (errors == 0) begin
            $display("nmea_rmc_time_extractor verification clean");
        end else begin
            $display("nmea_rmc_time_extractor verification failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/nrte_pkg.sv
rtl/nrte_front.sv
rtl/nrte_queue.sv
rtl/nrte_back.sv
rtl/nmea_rmc_time_extractor.sv
dv/tb_top.sv
